// ----- src/pdq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pdq_pkg
// shared constants, request and status codes, controller/datapath structs
// ----------------------------------------------------------------------------
package pdq_pkg;

    localparam int DEF_LIST_DEPTH  = 16;
    localparam int DEF_COORD_WIDTH = 16;

    localparam int REQ_W = 4;
    localparam int ST_W  = 2;

    // request codes
    localparam logic [REQ_W-1:0] REQ_PUSH_TOP = 4'd0;
    localparam logic [REQ_W-1:0] REQ_POP_TOP  = 4'd1;
    localparam logic [REQ_W-1:0] REQ_PUSH_BOT = 4'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BOT  = 4'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR    = 4'd4;
    localparam logic [REQ_W-1:0] REQ_FARTHEST = 4'd5;
    localparam logic [REQ_W-1:0] REQ_NEAREST  = 4'd6;
    localparam logic [REQ_W-1:0] REQ_COUNT    = 4'd7;
    localparam logic [REQ_W-1:0] REQ_READOUT  = 4'd8;

    // result status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic            load;
        logic            mul_en;
        logic            push_wr;
        logic            pop_apply;
        logic            clear_apply;
        logic            scan_init;
        logic            scan_rd;
        logic            scan_cmp;
        logic            fetch_best;
        logic            fetch_k;
        logic            rank_init;
        logic            rank_next;
        logic            k_inc;
        logic            flip_view;
        logic            emit;
        logic            emit_pt;
        logic            emit_last;
        logic [ST_W-1:0] emit_status;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             empty;
        logic             full;
        logic             view_stored;
        logic             k_last;
        logic             rank_last;
        logic             mul_done;
        logic             out_free;
    } t_stat;

endpackage
`default_nettype wire

// ----- src/pdq_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pdq_ctrl
// request sequencer: decode, push multiply, scans, readout and result emit
// ----------------------------------------------------------------------------
module pdq_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    output logic           o_in_ready,
    input  pdq_pkg::t_stat i_stat,
    output pdq_pkg::t_cmd  o_cmd
);
    import pdq_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE       = 11'b00000000001,
        S_DECODE     = 11'b00000000010,
        S_MUL        = 11'b00000000100,
        S_WRITE      = 11'b00000001000,
        S_SCAN_RD    = 11'b00000010000,
        S_SCAN_CMP   = 11'b00000100000,
        S_FETCH      = 11'b00001000000,
        S_EMIT_ONE   = 11'b00010000000,
        S_EMIT_SORT  = 11'b00100000000,
        S_STORE_RD   = 11'b01000000000,
        S_EMIT_STORE = 11'b10000000000
    } t_state;

    t_state          r_state, n_state;
    logic [ST_W-1:0] r_code, n_code;
    logic            r_pt, n_pt;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        n_pt    = r_pt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                n_code  = ST_OK;
                n_pt    = 1'b0;
                n_state = S_EMIT_ONE;
                unique case (i_stat.req)
                    REQ_PUSH_TOP, REQ_PUSH_BOT: begin
                        if (i_stat.full) n_code = ST_FULL;
                        else             n_state = S_MUL;
                    end
                    REQ_POP_TOP, REQ_POP_BOT: begin
                        if (i_stat.empty) n_code = ST_EMPTY;
                        else              o_cmd.pop_apply = 1'b1;
                    end
                    REQ_CLEAR: o_cmd.clear_apply = 1'b1;
                    REQ_FARTHEST, REQ_NEAREST: begin
                        if (i_stat.empty) begin
                            n_code = ST_EMPTY;
                        end else begin
                            o_cmd.scan_init = 1'b1;
                            n_state         = S_SCAN_RD;
                        end
                    end
                    REQ_READOUT: begin
                        if (i_stat.empty) begin
                            n_code = ST_EMPTY;
                        end else begin
                            o_cmd.scan_init = 1'b1;
                            o_cmd.rank_init = 1'b1;
                            n_state = i_stat.view_stored ? S_STORE_RD : S_SCAN_RD;
                        end
                    end
                    default: n_code = ST_OK;
                endcase
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                if (i_stat.mul_done) n_state = S_WRITE;
            end
            S_WRITE: begin
                o_cmd.push_wr = 1'b1;
                n_state       = S_EMIT_ONE;
            end
            S_SCAN_RD: begin
                o_cmd.scan_rd = 1'b1;
                n_state       = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                o_cmd.scan_cmp = 1'b1;
                n_state = i_stat.k_last ? S_FETCH : S_SCAN_RD;
            end
            S_FETCH: begin
                o_cmd.fetch_best = 1'b1;
                n_code           = ST_OK;
                n_pt             = 1'b1;
                n_state = (i_stat.req == REQ_READOUT) ? S_EMIT_SORT : S_EMIT_ONE;
            end
            S_EMIT_ONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_status = r_code;
                    o_cmd.emit_pt     = r_pt;
                    o_cmd.emit_last   = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_EMIT_SORT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_status = ST_OK;
                    o_cmd.emit_pt     = 1'b1;
                    o_cmd.emit_last   = i_stat.rank_last;
                    o_cmd.rank_next   = 1'b1;
                    if (i_stat.rank_last) begin
                        o_cmd.flip_view = 1'b1;
                        n_state         = S_IDLE;
                    end else begin
                        o_cmd.scan_init = 1'b1;
                        n_state         = S_SCAN_RD;
                    end
                end
            end
            S_STORE_RD: begin
                o_cmd.fetch_k = 1'b1;
                n_state       = S_EMIT_STORE;
            end
            S_EMIT_STORE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_status = ST_OK;
                    o_cmd.emit_pt     = 1'b1;
                    o_cmd.emit_last   = i_stat.k_last;
                    o_cmd.k_inc       = 1'b1;
                    if (i_stat.k_last) begin
                        o_cmd.flip_view = 1'b1;
                        n_state         = S_IDLE;
                    end else begin
                        n_state = S_STORE_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_code  <= ST_OK;
            r_pt    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
            r_pt    <= n_pt;
        end
    end

endmodule
`default_nettype wire

// ----- src/pdq_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pdq_dp
// point store, ring pointers, squared distance unit, scan compare, output reg
// ----------------------------------------------------------------------------
module pdq_dp #(
    parameter int LIST_DEPTH  = pdq_pkg::DEF_LIST_DEPTH,
    parameter int COORD_WIDTH = pdq_pkg::DEF_COORD_WIDTH
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  pdq_pkg::t_cmd                           i_cmd,
    output pdq_pkg::t_stat                          o_stat,
    input  wire        [pdq_pkg::REQ_W-1:0]         i_req,
    input  wire signed [COORD_WIDTH-1:0]            i_x,
    input  wire signed [COORD_WIDTH-1:0]            i_y,
    input  wire signed [COORD_WIDTH-1:0]            i_z,
    input  wire                                     i_out_ready,
    output logic                                    o_out_valid,
    output logic       [pdq_pkg::ST_W-1:0]          o_status,
    output logic signed [COORD_WIDTH-1:0]           o_x,
    output logic signed [COORD_WIDTH-1:0]           o_y,
    output logic signed [COORD_WIDTH-1:0]           o_z,
    output logic       [$clog2(LIST_DEPTH)-1:0]     o_pos,
    output logic       [$clog2(LIST_DEPTH+1)-1:0]   o_count,
    output logic                                    o_last
);
    import pdq_pkg::*;

    localparam int C  = COORD_WIDTH;
    localparam int PW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int DW = 2 * COORD_WIDTH;
    localparam int EW = 3 * COORD_WIDTH + DW;

    // entry layout: {x, y, z, dist}
    logic [EW-1:0] r_mem [LIST_DEPTH];
    logic [EW-1:0] r_rd;

    logic [REQ_W-1:0]    r_req;
    logic signed [C-1:0] r_x, r_y, r_z;
    logic [PW-1:0]       r_bp;
    logic [CW-1:0]       r_cnt;
    logic                r_view;
    logic [1:0]          r_mstep;
    logic [DW-1:0]       r_prod, r_acc;
    logic [PW-1:0]       r_k, r_rank;
    logic                r_best_valid, r_prev_valid;
    logic [DW-1:0]       r_best_dist, r_prev_dist;
    logic [PW-1:0]       r_best_idx, r_prev_idx;

    function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] bp,
                                              input logic [PW-1:0] k);
        logic [PW:0] s;
        s = {1'b0, bp} + {1'b0, k};
        if (s >= (PW+1)'(LIST_DEPTH)) s = s - (PW+1)'(LIST_DEPTH);
        return s[PW-1:0];
    endfunction

    logic [PW-1:0] bp_dec, bp_inc;
    assign bp_dec = (r_bp == '0) ? PW'(LIST_DEPTH - 1) : r_bp - 1'b1;
    assign bp_inc = (r_bp == PW'(LIST_DEPTH - 1)) ? '0 : r_bp + 1'b1;

    // squared distance, one coordinate per cycle
    logic signed [C-1:0]  mul_op;
    logic signed [DW-1:0] mul_sq;
    always_comb begin
        unique case (r_mstep)
            2'd0:    mul_op = r_x;
            2'd1:    mul_op = r_y;
            default: mul_op = r_z;
        endcase
    end
    assign mul_sq = mul_op * mul_op;

    // read data fields
    logic [DW-1:0]       rd_dist;
    logic signed [C-1:0] rd_x, rd_y, rd_z;
    assign rd_dist = r_rd[DW-1:0];
    assign rd_z    = r_rd[DW+C-1:DW];
    assign rd_y    = r_rd[DW+2*C-1:DW+C];
    assign rd_x    = r_rd[EW-1:DW+2*C];

    // scan compare: max, min, or next key in stable ascending order
    logic [DW+PW-1:0] key_cur, key_best, key_prev;
    logic             take;
    assign key_cur  = {rd_dist, r_k};
    assign key_best = {r_best_dist, r_best_idx};
    assign key_prev = {r_prev_dist, r_prev_idx};
    always_comb begin
        priority if (r_req == REQ_FARTHEST) begin
            take = !r_best_valid || (rd_dist > r_best_dist);
        end else if (r_req == REQ_NEAREST) begin
            take = !r_best_valid || (rd_dist < r_best_dist);
        end else begin
            take = (!r_prev_valid || (key_cur > key_prev)) &&
                   (!r_best_valid || (key_cur < key_best));
        end
    end

    // memory port
    logic          rd_en;
    logic [PW-1:0] rd_addr, wr_addr;
    assign rd_en   = i_cmd.scan_rd | i_cmd.fetch_k | i_cmd.fetch_best;
    assign rd_addr = i_cmd.fetch_best ? slot_of(r_bp, r_best_idx) : slot_of(r_bp, r_k);
    assign wr_addr = (r_req == REQ_PUSH_TOP) ? slot_of(r_bp, r_cnt[PW-1:0]) : bp_dec;

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_wr) r_mem[wr_addr] <= {r_x, r_y, r_z, r_acc};
        if (rd_en)         r_rd <= r_mem[rd_addr];
    end

    logic out_free;
    assign out_free = !o_out_valid || i_out_ready;

    // reported position
    logic [PW-1:0] emit_pos;
    always_comb begin
        priority if (!i_cmd.emit_pt)       emit_pos = '0;
        else if (r_req != REQ_READOUT)     emit_pos = r_best_idx;
        else if (r_view)                   emit_pos = r_k;
        else                               emit_pos = r_rank;
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
            r_x   <= i_x;
            r_y   <= i_y;
            r_z   <= i_z;
            r_acc <= '0;
        end
        if (i_cmd.mul_en) begin
            if (r_mstep != 2'd3) r_prod <= mul_sq;
            if (r_mstep != 2'd0) r_acc  <= r_acc + r_prod;
        end
        if (i_cmd.scan_cmp && take) begin
            r_best_dist <= rd_dist;
            r_best_idx  <= r_k;
        end
        if (i_cmd.rank_next) begin
            r_prev_dist <= r_best_dist;
            r_prev_idx  <= r_best_idx;
        end
        if (i_cmd.emit) begin
            o_status <= i_cmd.emit_status;
            o_x      <= i_cmd.emit_pt ? rd_x : '0;
            o_y      <= i_cmd.emit_pt ? rd_y : '0;
            o_z      <= i_cmd.emit_pt ? rd_z : '0;
            o_pos    <= emit_pos;
            o_count  <= r_cnt;
            o_last   <= i_cmd.emit_last;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bp         <= '0;
            r_cnt        <= '0;
            r_view       <= 1'b0;
            r_mstep      <= '0;
            r_k          <= '0;
            r_rank       <= '0;
            r_best_valid <= 1'b0;
            r_prev_valid <= 1'b0;
            o_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.load)   r_mstep <= '0;
            if (i_cmd.mul_en) r_mstep <= r_mstep + 2'd1;
            if (i_cmd.push_wr) begin
                if (r_req == REQ_PUSH_BOT) r_bp <= bp_dec;
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.pop_apply) begin
                if (r_req == REQ_POP_BOT) r_bp <= bp_inc;
                r_cnt <= r_cnt - 1'b1;
            end
            if (i_cmd.clear_apply) begin
                r_bp  <= '0;
                r_cnt <= '0;
            end
            if (i_cmd.scan_cmp && take) r_best_valid <= 1'b1;
            if (i_cmd.scan_cmp || i_cmd.k_inc) r_k <= r_k + 1'b1;
            if (i_cmd.scan_init) begin
                r_k          <= '0;
                r_best_valid <= 1'b0;
            end
            if (i_cmd.rank_next) begin
                r_rank       <= r_rank + 1'b1;
                r_prev_valid <= 1'b1;
            end
            if (i_cmd.rank_init) begin
                r_rank       <= '0;
                r_prev_valid <= 1'b0;
            end
            if (i_cmd.flip_view) r_view <= !r_view;
            if (i_cmd.emit)      o_out_valid <= 1'b1;
            else if (i_out_ready) o_out_valid <= 1'b0;
        end
    end

    always_comb begin
        o_stat.req         = r_req;
        o_stat.empty       = (r_cnt == '0);
        o_stat.full        = (r_cnt == CW'(LIST_DEPTH));
        o_stat.view_stored = r_view;
        o_stat.k_last      = (CW'(r_k) + CW'(1)) == r_cnt;
        o_stat.rank_last   = (CW'(r_rank) + CW'(1)) == r_cnt;
        o_stat.mul_done    = (r_mstep == 2'd3);
        o_stat.out_free    = out_free;
    end

endmodule
`default_nettype wire

// ----- src/point_deque_with_distance_query.sv -----
`default_nettype none
// result steps: push squares the coordinates and writes the entry; pop, clear, count and
//   refused requests answer straight from decode; farthest or nearest read each held entry once
// readout: sorted order runs one selection scan per rank, stored order reads the entries
//   in turn; the next request is taken once the last item is in the result register
// reset: synchronous active low; clears pointers, count, view flag and control,
//   the point store itself is not cleared
// ----------------------------------------------------------------------------
// point_deque_with_distance_query
// bounded double-ended list of 3d points with squared distance queries
// ----------------------------------------------------------------------------
module point_deque_with_distance_query #(
    parameter int LIST_DEPTH  = pdq_pkg::DEF_LIST_DEPTH,
    parameter int COORD_WIDTH = pdq_pkg::DEF_COORD_WIDTH
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // request channel
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    // tdata: x_coord, y_coord, z_coord
    input  wire  [((3*COORD_WIDTH+7)/8)*8-1:0] i_s_tdata,
    // tuser: req_type
    input  wire  [pdq_pkg::REQ_W-1:0]          i_s_tuser,
    // result channel
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    // tdata: status, out_x, out_y, out_z, position, entry_count
    output logic [((2+3*COORD_WIDTH+$clog2(LIST_DEPTH)+$clog2(LIST_DEPTH+1)+7)/8)*8-1:0]
                        o_m_tdata,
    output logic        o_m_tlast
);
    import pdq_pkg::*;

    localparam int C     = COORD_WIDTH;
    localparam int PW    = $clog2(LIST_DEPTH);
    localparam int CW    = $clog2(LIST_DEPTH + 1);
    localparam int OBITS = ST_W + 3 * C + PW + CW;
    localparam int OW    = ((OBITS + 7) / 8) * 8;

    t_cmd  cmd;
    t_stat stat;

    logic [ST_W-1:0]     res_status;
    logic signed [C-1:0] res_x, res_y, res_z;
    logic [PW-1:0]       res_pos;
    logic [CW-1:0]       res_count;

    // sequencer
    pdq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // store, distance unit, scan compare and result register
    pdq_dp #(
        .LIST_DEPTH  (LIST_DEPTH),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_req       (i_s_tuser),
        .i_x         (i_s_tdata[C-1:0]),
        .i_y         (i_s_tdata[2*C-1:C]),
        .i_z         (i_s_tdata[3*C-1:2*C]),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_status    (res_status),
        .o_x         (res_x),
        .o_y         (res_y),
        .o_z         (res_z),
        .o_pos       (res_pos),
        .o_count     (res_count),
        .o_last      (o_m_tlast)
    );

    // pack result fields from the lowest bit up
    assign o_m_tdata = OW'({res_count, res_pos, res_z, res_y, res_x, res_status});

`ifndef SYNTHESIS
    // a request is decoded before the next one can be taken
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("request accepted while previous one in work");

    // a refused push only happens on a full list
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && res_status == ST_FULL) |-> (res_count == CW'(LIST_DEPTH)))
        else $error("full status with list not full");

    // an empty status only happens on an empty list
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && res_status == ST_EMPTY) |-> (res_count == '0))
        else $error("empty status with points held");

    // a result marked empty or full is always the only item of its request
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && res_status != ST_OK) |-> o_m_tlast)
        else $error("status item not marked last");
`endif

endmodule
`default_nettype wire

// ----- dv/tb_point_deque_with_distance_query.sv -----
// ----------------------------------------------------------------------------
// tb_point_deque_with_distance_query
// self-checking bench for the point deque: random and directed requests go
// through a queue-fed driver, a clocked monitor compares every result item
// against a behavioral copy of the deque kept inside the bench
// ----------------------------------------------------------------------------
module tb_point_deque_with_distance_query;
    import pdq_pkg::*;

    localparam int DEPTH = 16;
    localparam int CW    = 16;
    localparam int DIN_W = ((3*CW+7)/8)*8;
    localparam int DOUT_W = ((2+3*CW+4+5+7)/8)*8;

    // one request item as driven
    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } t_req;

    // one result item as expected
    typedef struct packed {
        logic [ST_W-1:0] status;
        logic [CW-1:0] ox;
        logic [CW-1:0] oy;
        logic [CW-1:0] oz;
        logic [3:0] pos;
        logic [4:0] cnt;
        logic last;
    } t_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_tvalid = 1'b0;
    logic [DIN_W-1:0] i_s_tdata = '0;
    logic [REQ_W-1:0] i_s_tuser = '0;
    logic i_m_tready = 1'b0;
    logic o_s_tready, o_m_tvalid, o_m_tlast;
    logic [DOUT_W-1:0] o_m_tdata;

    always #5 i_clk = ~i_clk;

    point_deque_with_distance_query DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tlast(o_m_tlast)
    );

    // bench copy of the deque state
    logic signed [CW-1:0] px[DEPTH], py[DEPTH], pz[DEPTH];
    logic [33:0] pdist[DEPTH];
    int unsigned bot_slot = 0, n_held = 0;
    bit stored_view = 0;

    t_req pending_reqs[$];
    t_res expected_results[$];
    int errors = 0, n_sent = 0, n_seen = 0, n_readouts = 0, n_full = 0;
    bit stim_done = 0, calm = 0, hold_off = 0;
    int idle_s = 0, idle_m = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch on result %0d: %s got %0h want %0h", n_seen, what, got, want);
        errors++;
    endtask

    task automatic queue_req(input t_req q);
        pending_reqs = {pending_reqs, q};
    endtask

    task automatic expect_res(input t_res r);
        expected_results = {expected_results, r};
    endtask

    function automatic int unsigned slot(input int unsigned k);
        return (bot_slot + k) % DEPTH;
    endfunction

    function automatic t_res plain(input logic [ST_W-1:0] st);
        t_res r;
        r = '0;
        r.status = st;
        r.cnt = n_held[4:0];
        r.last = 1'b1;
        return r;
    endfunction

    function automatic t_res with_point(input int unsigned k, input int unsigned p,
                                        input bit fin);
        t_res r;
        int unsigned s;
        s = slot(k);
        r = plain(ST_OK);
        r.ox = px[s]; r.oy = py[s]; r.oz = pz[s];
        r.pos = p[3:0];
        r.last = fin;
        return r;
    endfunction

    // applies one request to the bench deque and queues what it should produce
    task automatic predict_deque(input t_req q);
        int unsigned s, best, order[DEPTH], v, j;
        logic signed [33:0] dx, dy, dz;
        case (q.req)
            REQ_PUSH_TOP, REQ_PUSH_BOT: begin
                if (n_held >= DEPTH) begin
                    n_full++;
                    expect_res(plain(ST_FULL));
                end else begin
                    if (q.req == REQ_PUSH_TOP) s = slot(n_held);
                    else begin
                        bot_slot = (bot_slot + DEPTH - 1) % DEPTH;
                        s = bot_slot;
                    end
                    px[s] = q.x; py[s] = q.y; pz[s] = q.z;
                    dx = q.x; dy = q.y; dz = q.z;
                    pdist[s] = dx*dx + dy*dy + dz*dz;
                    n_held++;
                    expect_res(plain(ST_OK));
                end
            end
            REQ_POP_TOP, REQ_POP_BOT: begin
                if (n_held == 0) expect_res(plain(ST_EMPTY));
                else begin
                    if (q.req == REQ_POP_BOT) bot_slot = (bot_slot + 1) % DEPTH;
                    n_held--;
                    expect_res(plain(ST_OK));
                end
            end
            REQ_CLEAR: begin
                n_held = 0;
                bot_slot = 0;
                expect_res(plain(ST_OK));
            end
            REQ_FARTHEST, REQ_NEAREST: begin
                if (n_held == 0) expect_res(plain(ST_EMPTY));
                else begin
                    best = 0;
                    for (int unsigned k = 1; k < n_held; k++)
                        if (q.req == REQ_FARTHEST ? pdist[slot(k)] > pdist[slot(best)]
                                                  : pdist[slot(k)] < pdist[slot(best)])
                            best = k;
                    expect_res(with_point(best, best, 1'b1));
                end
            end
            REQ_READOUT: begin
                if (n_held == 0) expect_res(plain(ST_EMPTY));
                else begin
                    n_readouts++;
                    for (int unsigned k = 0; k < n_held; k++) order[k] = k;
                    // stable ascending sort by squared distance
                    if (!stored_view)
                        for (int unsigned k = 1; k < n_held; k++) begin
                            v = order[k];
                            j = k;
                            while (j > 0 && pdist[slot(order[j-1])] > pdist[slot(v)]) begin
                                order[j] = order[j-1];
                                j--;
                            end
                            order[j] = v;
                        end
                    for (int unsigned k = 0; k < n_held; k++)
                        expect_res(with_point(order[k],
                            stored_view ? order[k] : k, k + 1 == n_held));
                    stored_view = !stored_view;
                end
            end
            default: expect_res(plain(ST_OK));
        endcase
    endtask

    function automatic logic signed [CW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return CW'($urandom_range(0, 7) - 4);
            default: return CW'($urandom);
        endcase
    endfunction

    function automatic t_req make_req(input logic [REQ_W-1:0] r);
        t_req q;
        q.req = r;
        q.x = rand_coord(); q.y = rand_coord(); q.z = rand_coord();
        return q;
    endfunction

    // driver: offers the next pending item, random idle bursts between items
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                n_sent++;
                predict_deque(pending_reqs[0]);
                pending_reqs.delete(0);
            end
            if (idle_s > 0) begin
                idle_s <= idle_s - 1;
                i_s_tvalid <= 1'b0;
            end else if ((!i_s_tvalid || o_s_tready) && !calm && $urandom_range(0, 5) == 0) begin
                idle_s <= $urandom_range(0, 2);
                i_s_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata <= {pending_reqs[0].z, pending_reqs[0].y, pending_reqs[0].x};
                i_s_tuser <= pending_reqs[0].req;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // monitor: checks every accepted result item, stalls the result side
    always @(posedge i_clk) begin
        t_res got, want;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                got.status = o_m_tdata[1:0];
                got.ox = o_m_tdata[17:2];
                got.oy = o_m_tdata[33:18];
                got.oz = o_m_tdata[49:34];
                got.pos = o_m_tdata[53:50];
                got.cnt = o_m_tdata[58:54];
                got.last = o_m_tlast;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected item", 64'(got), 64'(0));
                end else begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    if (got.status !== want.status)
                        report_mismatch("status", 64'(got.status), 64'(want.status));
                    if (got.ox !== want.ox) report_mismatch("out_x", 64'(got.ox), 64'(want.ox));
                    if (got.oy !== want.oy) report_mismatch("out_y", 64'(got.oy), 64'(want.oy));
                    if (got.oz !== want.oz) report_mismatch("out_z", 64'(got.oz), 64'(want.oz));
                    if (got.pos !== want.pos)
                        report_mismatch("position", 64'(got.pos), 64'(want.pos));
                    if (got.cnt !== want.cnt)
                        report_mismatch("entry_count", 64'(got.cnt), 64'(want.cnt));
                    if (got.last !== want.last)
                        report_mismatch("last", 64'(got.last), 64'(want.last));
                end
                n_seen++;
            end
            if (hold_off) begin
                i_m_tready <= 1'b0;
            end else if (idle_m > 0) begin
                idle_m <= idle_m - 1;
                i_m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                idle_m <= $urandom_range(0, 2);
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // long receiver hold-off so the block backs up and stalls requests
    initial begin
        wait (n_sent >= 40);
        hold_off = 1;
        repeat (600) @(posedge i_clk);
        hold_off = 0;
    end

    initial begin
        int r;
        // directed: empty-list cases, unknown type, fill past full, queries, count, readouts, clear
        queue_req(make_req(REQ_POP_TOP));
        queue_req(make_req(REQ_POP_BOT));
        queue_req(make_req(REQ_FARTHEST));
        queue_req(make_req(REQ_NEAREST));
        queue_req(make_req(REQ_READOUT));
        queue_req(make_req(4'd15));
        queue_req(make_req(4'd9));
        queue_req('{REQ_PUSH_TOP, 16'sh7fff, 16'sh7fff, 16'sh7fff});
        queue_req('{REQ_PUSH_BOT, 16'sh8000, 16'sh8000, 16'sh8000});
        queue_req('{REQ_PUSH_TOP, 16'sh0, 16'sh0, 16'sh0});
        queue_req('{REQ_PUSH_BOT, 16'sh0, 16'sh0, 16'sh0}); // tie on nearest
        for (int k = 0; k < 13; k++) queue_req(make_req(k % 2 ? REQ_PUSH_BOT : REQ_PUSH_TOP));
        queue_req(make_req(REQ_FARTHEST));
        queue_req(make_req(REQ_NEAREST));
        queue_req(make_req(REQ_COUNT));
        queue_req(make_req(REQ_READOUT));
        queue_req(make_req(REQ_READOUT));
        queue_req(make_req(REQ_CLEAR));
        // random: mostly pushes and queries with occasional pops, clears and junk
        for (int k = 0; k < 200; k++) begin
            r = $urandom_range(0, 99);
            if (r < 35) queue_req(make_req($urandom_range(0, 1) ? REQ_PUSH_TOP : REQ_PUSH_BOT));
            else if (r < 55) queue_req(make_req($urandom_range(0, 1) ? REQ_POP_TOP : REQ_POP_BOT));
            else if (r < 58) queue_req(make_req(REQ_CLEAR));
            else if (r < 70) queue_req(make_req(REQ_FARTHEST));
            else if (r < 82) queue_req(make_req(REQ_NEAREST));
            else if (r < 87) queue_req(make_req(REQ_COUNT));
            else if (r < 96) queue_req(make_req(REQ_READOUT));
            else queue_req(make_req(REQ_W'($urandom_range(9, 15))));
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_reqs.size() < 40);
        calm = 1;
        wait (pending_reqs.size() == 0 && !i_s_tvalid);
        wait (expected_results.size() == 0);
        repeat (700) @(posedge i_clk);
        $display("covered %0d requests, %0d result items, %0d non-empty readouts, %0d full refusals",
                 n_sent, n_seen, n_readouts, n_full);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // watchdog, far above the slowest legal run
    initial begin
        #20000000;
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("status: fail");
        $finish;
    end
endmodule
